FILE: hdl/lru_pkg.sv
// Shared constants, codes and controller/datapath link types for the LRU index tracker.
// No dependencies; every other file in hdl/ imports this package.
package lru_pkg;

   localparam int MAX_INDICES_DEF = 1024;
   localparam int MAX_SLOTS_DEF   = 64;

   localparam int INDEX_W  = 10;
   localparam int CAP_W    = 7;
   localparam int LIMIT_W  = 11;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 11;

   localparam logic [CAP_W-1:0]   CAP_RESET   = 7'd64;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TOUCH  = 1'b1;

   localparam logic CSR_CAPACITY    = 1'b0;
   localparam logic CSR_INDEX_LIMIT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EVICTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ERROR   = 2'd2;

   typedef struct packed {
      logic                load;       // capture request word
      logic                sweep;      // clear one map entry, advance
      logic                map_rd;     // read map at request index
      logic                alloc;      // insert into a fresh slot
      logic                evict;      // insert by reusing the back slot
      logic                evict_clr;  // drop the evicted index from the map
      logic                touch_rd;   // read links of the touched slot
      logic                unlink;     // splice touched slot out of the list
      logic                front_move; // link touched slot at the front
      logic                respond;
      logic [STATUS_W-1:0] rsp_code;
   } lru_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic limit_ok;
      logic present;
      logic full;
      logic at_front;
      logic op_touch;
   } lru_stat_type;

endpackage

FILE: hdl/lru_ctrl.sv
// Sequencer for the LRU index tracker: clearing pass, then per-word steps.
// Depends on lru_pkg; drives lru_datapath through lru_cmd_type.
module lru_ctrl
   import lru_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         csr_we,
   input  lru_stat_type stat,
   output lru_cmd_type  cmd,
   output logic         busy
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_MAPRD  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_EVICT  = 3'd4;
   localparam logic [2:0] ST_TOUCH1 = 3'd5;
   localparam logic [2:0] ST_TOUCH2 = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_MAPRD;
            end
         end
         ST_MAPRD: begin
            cmd.map_rd = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!stat.limit_ok || (stat.op_touch != stat.present)) begin
               // out of range, insert of a resident index, touch of an absent one
               cmd.respond  = 1'b1;
               cmd.rsp_code = STATUS_ERROR;
               state_in     = ST_IDLE;
            end else if (!stat.op_touch) begin
               if (!stat.full) begin
                  cmd.alloc    = 1'b1;
                  cmd.respond  = 1'b1;
                  cmd.rsp_code = STATUS_DONE;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.evict = 1'b1;
                  state_in  = ST_EVICT;
               end
            end else if (stat.at_front) begin
               cmd.respond  = 1'b1;
               cmd.rsp_code = STATUS_DONE;
               state_in     = ST_IDLE;
            end else begin
               cmd.touch_rd = 1'b1;
               state_in     = ST_TOUCH1;
            end
         end
         ST_EVICT: begin
            cmd.evict_clr = 1'b1;
            cmd.respond   = 1'b1;
            cmd.rsp_code  = STATUS_EVICTED;
            state_in      = ST_IDLE;
         end
         ST_TOUCH1: begin
            cmd.unlink = 1'b1;
            state_in   = ST_TOUCH2;
         end
         ST_TOUCH2: begin
            cmd.front_move = 1'b1;
            cmd.respond    = 1'b1;
            cmd.rsp_code   = STATUS_DONE;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      // any register write empties the list: restart the clearing pass
      if (csr_we) state_in = ST_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/lru_datapath.sv
// Datapath of the LRU index tracker: index map RAM, slot owner and link RAMs,
// list head/tail/count, configuration and result registers. Depends on lru_pkg.
module lru_datapath
   import lru_pkg::*;
#(
   parameter int MAX_INDICES = MAX_INDICES_DEF,
   parameter int MAX_SLOTS   = MAX_SLOTS_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  lru_cmd_type         cmd,
   output lru_stat_type        stat,
   input  logic                req_op,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_wdata,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [INDEX_W-1:0]  rsp_evicted_index
);

   localparam int MAP_AW = $clog2(MAX_INDICES);
   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int MAPE_W = SLOT_W + 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int WIDE_W = (MAP_AW > INDEX_W) ? MAP_AW : INDEX_W;

   // memories
   logic [MAPE_W-1:0]  map_mem   [MAX_INDICES];
   logic [INDEX_W-1:0] owner_mem [MAX_SLOTS];
   logic [SLOT_W-1:0]  next_mem  [MAX_SLOTS];
   logic [SLOT_W-1:0]  prev_mem  [MAX_SLOTS];

   logic [MAPE_W-1:0]  map_rd;
   logic [INDEX_W-1:0] owner_rd;
   logic [SLOT_W-1:0]  next_rd, prev_rd;

   logic               map_we;
   logic [MAP_AW-1:0]  map_addr;
   logic [MAPE_W-1:0]  map_wd;
   logic               owner_we;
   logic [SLOT_W-1:0]  owner_wa;
   logic               next_we, prev_we;
   logic [SLOT_W-1:0]  next_wa, next_wd, prev_wa, prev_wd;
   logic [SLOT_W-1:0]  prev_ra;

   // registers
   logic [SLOT_W-1:0]   front_ff, front_in, back_ff, back_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CAP_W-1:0]    cap_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [MAP_AW-1:0]   sweep_ff;
   logic [INDEX_W-1:0]  idx_ff, evicted_ff;
   logic                op_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [INDEX_W-1:0]  rsp_evicted_ff;

   logic [SLOT_W-1:0]  s_now, alloc_slot, push_x;
   logic [CAP_W-1:0]   cap_eff;
   logic [WIDE_W-1:0]  idx_wide, evicted_wide;

   always_comb begin
      s_now        = SLOT_W'(map_rd - MAPE_W'(1));
      alloc_slot   = SLOT_W'(count_ff);
      cap_eff      = (cap_ff == '0) ? CAP_W'(1) : cap_ff;
      idx_wide     = WIDE_W'(idx_ff);
      evicted_wide = WIDE_W'(evicted_ff);

      stat.sweep_last = (sweep_ff == MAP_AW'(MAX_INDICES - 1));
      stat.limit_ok   = (LIMIT_W'(idx_ff) < limit_ff) && (32'(idx_ff) < MAX_INDICES);
      stat.present    = (map_rd != '0);
      stat.full       = (32'(count_ff) >= 32'(cap_eff)) || (32'(count_ff) >= MAX_SLOTS);
      stat.at_front   = (s_now == front_ff);
      stat.op_touch   = (op_ff == OP_TOUCH);
   end

   // list update
   always_comb begin
      if (cmd.alloc)      push_x = alloc_slot;
      else if (cmd.evict) push_x = back_ff;
      else                push_x = slot_ff;

      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      next_we  = 1'b0;
      next_wa  = push_x;
      next_wd  = front_ff;
      prev_we  = 1'b0;
      prev_wa  = front_ff;
      prev_wd  = push_x;

      if (cmd.alloc) begin
         count_in = count_ff + CNT_W'(1);
         if (count_ff == '0) begin
            front_in = alloc_slot;
            back_in  = alloc_slot;
         end else begin
            next_we  = 1'b1;
            prev_we  = 1'b1;
            front_in = push_x;
         end
      end
      if (cmd.evict && (front_ff != back_ff)) begin
         back_in  = prev_rd;
         next_we  = 1'b1;
         prev_we  = 1'b1;
         front_in = push_x;
      end
      if (cmd.unlink) begin
         if (slot_ff == back_ff) begin
            back_in = prev_rd;
         end else begin
            next_we = 1'b1;
            next_wa = prev_rd;
            next_wd = next_rd;
            prev_we = 1'b1;
            prev_wa = next_rd;
            prev_wd = prev_rd;
         end
      end
      if (cmd.front_move) begin
         next_we  = 1'b1;
         prev_we  = 1'b1;
         front_in = push_x;
      end

      owner_we = cmd.alloc | cmd.evict;
      owner_wa = cmd.alloc ? alloc_slot : back_ff;
      prev_ra  = cmd.touch_rd ? s_now : back_ff;

      map_we = cmd.sweep | cmd.alloc | cmd.evict | cmd.evict_clr;
      if (cmd.sweep)          map_addr = sweep_ff;
      else if (cmd.evict_clr) map_addr = evicted_wide[MAP_AW-1:0];
      else                    map_addr = idx_wide[MAP_AW-1:0];
      map_wd = (cmd.alloc | cmd.evict) ? (MAPE_W'(push_x) + MAPE_W'(1)) : '0;
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_addr] <= map_wd;
      if (cmd.map_rd) map_rd <= map_mem[map_addr];
   end

   always_ff @(posedge clock) begin
      if (owner_we) owner_mem[owner_wa] <= idx_ff;
      owner_rd <= owner_mem[back_ff];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      next_rd <= next_mem[s_now];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      prev_rd <= prev_mem[prev_ra];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         limit_ff     <= LIMIT_RESET;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (csr_we) begin
            if (csr_index == CSR_CAPACITY) cap_ff <= csr_wdata[CAP_W-1:0];
            else                           limit_ff <= csr_wdata[LIMIT_W-1:0];
            front_ff <= '0;
            back_ff  <= '0;
            count_ff <= '0;
            sweep_ff <= '0;
         end else begin
            front_ff <= front_in;
            back_ff  <= back_in;
            count_ff <= count_in;
            if (cmd.sweep) sweep_ff <= sweep_ff + MAP_AW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= req_index;
         op_ff  <= req_op;
      end
      if (cmd.touch_rd) slot_ff <= s_now;
      if (cmd.evict) evicted_ff <= owner_rd;
      if (cmd.respond) begin
         rsp_status_ff  <= cmd.rsp_code;
         rsp_evicted_ff <= (cmd.rsp_code == STATUS_EVICTED) ? evicted_ff : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_evicted_index = rsp_evicted_ff;

endmodule

FILE: hdl/lru_index_tracker.sv
// Top level of the LRU index tracker: sequencer plus datapath.
// Depends on lru_pkg, lru_ctrl and lru_datapath.
//
//   channel  ports                                  handshake
//   request  req_op, req_index                      start high while busy low
//   result   rsp_status, rsp_evicted_index          rsp_valid, one cycle
//   config   csr_index, csr_wdata                   csr_we, no wait
//
// From the accepting edge to the result strobe the index map is read and the word
// decided; an insert with eviction adds a step that clears the evicted index from
// the map, and a touch that moves a slot adds an unlink step and a front-link step.
// busy drops in the strobe cycle, so a new word is taken no sooner than the result
// of the last; the single port of the index map and of each link RAM sets the step
// count. After reset and after every register write the map is swept clear, entry by
// entry, with busy high. Results cannot be held off: each shows for exactly one cycle.
module lru_index_tracker
   import lru_pkg::*;
#(
   parameter int MAX_INDICES = MAX_INDICES_DEF,
   parameter int MAX_SLOTS   = MAX_SLOTS_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_op,
   input  logic [INDEX_W-1:0]  req_index,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [INDEX_W-1:0]  rsp_evicted_index,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_wdata
);

   lru_cmd_type  cmd;
   lru_stat_type stat;

   lru_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .csr_we (csr_we),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   lru_datapath #(
      .MAX_INDICES (MAX_INDICES),
      .MAX_SLOTS   (MAX_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_index         (req_index),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_evicted_index (rsp_evicted_index)
   );

endmodule

FILE: hdl/lru_checker.sv
// Port-level checks for the LRU index tracker, bound to the top level.
// Depends on lru_pkg and lru_index_tracker.
module lru_checker
   import lru_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [INDEX_W-1:0]  rsp_evicted_index
);

   // accepted word keeps the block busy until its result
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after an accepted word");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_DONE || rsp_status == STATUS_EVICTED ||
                     rsp_status == STATUS_ERROR))
      else $error("undefined status code");

   a_evicted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_EVICTED) |-> (rsp_evicted_index == '0))
      else $error("evicted index nonzero without eviction");

   // one result per word, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

bind lru_index_tracker lru_checker u_lru_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_evicted_index (rsp_evicted_index)
);

FILE: tb/testbench.sv
// Self-checking bench for lru_index_tracker: directed rows, then random phases per setting.
// Depends on lru_pkg and the lru_index_tracker RTL; results come from an in-bench LRU model.
`timescale 1ns / 100ps

module testbench;
   import lru_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic                 op;
      logic [INDEX_W-1:0]   index;
      logic                 csr_sel;
      logic [CSR_W-1:0]     wdata;
      logic                 fixed;
      logic [STATUS_W-1:0]  status;
      logic [INDEX_W-1:0]   evicted;
   } plan_row_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  evicted;
   } lru_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_op = 1'b0;
   logic [INDEX_W-1:0]  req_index = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [INDEX_W-1:0]  rsp_evicted_index;
   logic                csr_we = 1'b0;
   logic                csr_index = 1'b0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   lru_index_tracker dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // LRU model state
   logic [CAP_W-1:0]   cap_reg;
   logic [LIMIT_W-1:0] lim_reg;
   int                 cap_eff;
   int                 lim_eff;
   logic [6:0]         slot_of [MAX_INDICES_DEF];   // 0 = absent, else slot + 1
   logic [INDEX_W-1:0] owner [MAX_SLOTS_DEF];
   logic [5:0]         next_slot [MAX_SLOTS_DEF];
   logic [5:0]         prev_slot [MAX_SLOTS_DEF];
   logic [5:0]         front;
   logic [5:0]         back;
   int                 resident;

   lru_result_type pending_results [$];
   int             mismatch_count = 0;
   int             cycles = 0;

   task automatic clear_tracker();
      cap_eff = (cap_reg == 0) ? 1 : (cap_reg > MAX_SLOTS_DEF ? MAX_SLOTS_DEF : int'(cap_reg));
      lim_eff = (lim_reg > MAX_INDICES_DEF) ? MAX_INDICES_DEF : int'(lim_reg);
      foreach (slot_of[i]) slot_of[i] = '0;
      front = '0;
      back = '0;
      resident = 0;
   endtask

   task automatic link_front(input int s);
      next_slot[s] = front;
      prev_slot[front] = 6'(s);
      front = 6'(s);
   endtask

   task automatic predict_lru_step(input logic op, input logic [INDEX_W-1:0] idx,
                                   output logic [STATUS_W-1:0] st,
                                   output logic [INDEX_W-1:0] ev);
      logic [6:0] entry;
      int         s;
      int         p;
      int         n;
      st = STATUS_ERROR;
      ev = '0;
      if (idx < lim_eff) begin
         entry = slot_of[idx];
         if (op == OP_INSERT && entry == 0) begin
            if (resident < cap_eff) begin
               s = resident;
               resident++;
               owner[s] = idx;
               if (resident == 1) begin
                  front = 6'(s);
                  back = 6'(s);
               end else begin
                  link_front(s);
               end
               slot_of[idx] = 7'(s + 1);
               st = STATUS_DONE;
            end else begin
               // reuse the back slot; with one slot it stays in place
               s = back;
               ev = owner[s];
               slot_of[ev] = '0;
               if (front != s) begin
                  back = prev_slot[s];
                  link_front(s);
               end
               owner[s] = idx;
               slot_of[idx] = 7'(s + 1);
               st = STATUS_EVICTED;
            end
         end else if (op == OP_TOUCH && entry != 0) begin
            s = entry - 1;
            if (s != front) begin
               p = prev_slot[s];
               if (s == back) begin
                  back = 6'(p);
               end else begin
                  n = next_slot[s];
                  next_slot[p] = 6'(n);
                  prev_slot[n] = 6'(p);
               end
               link_front(s);
            end
            st = STATUS_DONE;
         end
      end
   endtask

   task automatic report(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
   endtask

   // Hold start low until every pending word has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic idle_for(input int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic send_word(input logic op, input logic [INDEX_W-1:0] idx, input logic fixed,
                            input logic [STATUS_W-1:0] st_fix,
                            input logic [INDEX_W-1:0] ev_fix);
      logic [STATUS_W-1:0] st;
      logic [INDEX_W-1:0]  ev;
      start <= 1'b1;
      req_op <= op;
      req_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_lru_step(op, idx, st, ev);
      if (fixed) begin
         st = st_fix;
         ev = ev_fix;
      end
      pending_results.push_back('{status: st, evicted: ev});
      @(negedge clock);
   endtask

   task automatic program_reg(input logic sel, input logic [CSR_W-1:0] data);
      drain_results();
      while (busy) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_CAPACITY) cap_reg = data[CAP_W-1:0];
      else lim_reg = data;
      clear_tracker();
      // let the clear sweep raise busy
      repeat (2) @(negedge clock);
   endtask

   function automatic plan_row_type req_row(input logic op, input int idx, input logic fixed,
                                            input logic [STATUS_W-1:0] st, input int ev);
      return '{kind: ROW_REQ, op: op, index: INDEX_W'(idx), csr_sel: 1'b0, wdata: '0,
               fixed: fixed, status: st, evicted: INDEX_W'(ev)};
   endfunction

   function automatic plan_row_type csr_row(input logic sel, input int data);
      return '{kind: ROW_CSR, op: 1'b0, index: '0, csr_sel: sel, wdata: CSR_W'(data),
               fixed: 1'b0, status: '0, evicted: '0};
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      lru_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report("result with nothing pending", rsp_status, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report("status", rsp_status, want.status);
            if (rsp_evicted_index !== want.evicted)
               report("evicted_index", rsp_evicted_index, want.evicted);
         end
      end
   end

   initial begin : stimulus
      plan_row_type       plan [$];
      logic [CAP_W-1:0]   cap_v;
      logic [LIMIT_W-1:0] lim_v;
      logic               op;
      logic [INDEX_W-1:0] idx;
      int                 n_items;
      int                 pool;
      int                 base;
      int                 r;
      bit                 idle_on;

      cap_reg = CAP_RESET;
      lim_reg = LIMIT_RESET;
      clear_tracker();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // default setting: inserts, duplicate insert, absent touch, back/middle/front touches
      plan.push_back(req_row(OP_INSERT, 0, 1, STATUS_DONE, 0));
      plan.push_back(req_row(OP_INSERT, 1023, 1, STATUS_DONE, 0));
      plan.push_back(req_row(OP_INSERT, 1023, 1, STATUS_ERROR, 0));
      plan.push_back(req_row(OP_TOUCH, 7, 1, STATUS_ERROR, 0));
      plan.push_back(req_row(OP_TOUCH, 0, 0, STATUS_DONE, 0));
      plan.push_back(req_row(OP_TOUCH, 0, 1, STATUS_DONE, 0));
      plan.push_back(req_row(OP_INSERT, 512, 0, STATUS_DONE, 0));
      plan.push_back(req_row(OP_TOUCH, 0, 0, STATUS_DONE, 0));
      // capacity zero acts as one: eviction reuses the single slot
      plan.push_back(csr_row(CSR_CAPACITY, 0));
      plan.push_back(req_row(OP_INSERT, 3, 1, STATUS_DONE, 0));
      plan.push_back(req_row(OP_INSERT, 4, 1, STATUS_EVICTED, 3));
      plan.push_back(req_row(OP_TOUCH, 4, 1, STATUS_DONE, 0));
      plan.push_back(req_row(OP_TOUCH, 3, 1, STATUS_ERROR, 0));
      // limit above the index range is clipped
      plan.push_back(csr_row(CSR_CAPACITY, 2));
      plan.push_back(csr_row(CSR_INDEX_LIMIT, 2047));
      plan.push_back(req_row(OP_INSERT, 1023, 1, STATUS_DONE, 0));
      plan.push_back(req_row(OP_INSERT, 1, 1, STATUS_DONE, 0));
      plan.push_back(req_row(OP_INSERT, 2, 1, STATUS_EVICTED, 1023));
      plan.push_back(req_row(OP_TOUCH, 1, 0, STATUS_DONE, 0));
      plan.push_back(req_row(OP_INSERT, 9, 1, STATUS_EVICTED, 2));
      // limit zero rejects everything
      plan.push_back(csr_row(CSR_INDEX_LIMIT, 0));
      plan.push_back(req_row(OP_INSERT, 0, 1, STATUS_ERROR, 0));
      plan.push_back(req_row(OP_TOUCH, 0, 1, STATUS_ERROR, 0));
      // capacity above the slot count is clipped; index at the limit is rejected
      plan.push_back(csr_row(CSR_INDEX_LIMIT, 10));
      plan.push_back(csr_row(CSR_CAPACITY, 127));
      plan.push_back(req_row(OP_INSERT, 10, 1, STATUS_ERROR, 0));
      plan.push_back(req_row(OP_INSERT, 9, 1, STATUS_DONE, 0));
      plan.push_back(req_row(OP_TOUCH, 9, 1, STATUS_DONE, 0));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR)
            program_reg(plan[i].csr_sel, plan[i].wdata);
         else
            send_word(plan[i].op, plan[i].index, plan[i].fixed, plan[i].status,
                      plan[i].evicted);
      end

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin cap_v = 7'd1;   lim_v = 11'd1024; end
            1: begin cap_v = 7'd64;  lim_v = 11'd1024; end
            2: begin cap_v = 7'd64;  lim_v = 11'd96;   end
            3: begin cap_v = 7'd127; lim_v = 11'd2047; end
            4: begin cap_v = 7'd0;   lim_v = 11'd4;    end
            5: begin cap_v = 7'd64;  lim_v = 11'd0;    end
            6: begin cap_v = 7'd2;   lim_v = 11'd1;    end
            default: begin
               cap_v = 7'($urandom_range(1, 64));
               lim_v = 11'($urandom_range(1, 1024));
            end
         endcase
         // junk above the capacity field must be dropped
         program_reg(CSR_CAPACITY, {4'($urandom), cap_v});
         program_reg(CSR_INDEX_LIMIT, lim_v);

         n_items = (lim_eff == 0) ? 40 : 205;
         pool = (lim_eff < 2 * cap_eff + 3) ? lim_eff : 2 * cap_eff + 3;
         base = (pool == 0) ? 0 : $urandom_range(0, lim_eff - pool);
         idle_on = 0;
         for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) idle_on = (ph != 9) && ($urandom_range(0, 2) != 0);
            if (k == n_items / 2) drain_results();
            r = $urandom_range(0, 9);
            if (pool == 0 || r == 9) begin
               op = 1'($urandom);
               idx = INDEX_W'($urandom);
            end else if (r < 4 && resident != 0) begin
               op = OP_TOUCH;
               idx = owner[$urandom_range(0, resident - 1)];
            end else if (r < 8) begin
               op = OP_INSERT;
               idx = INDEX_W'(base + $urandom_range(0, pool - 1));
            end else begin
               op = 1'($urandom);
               idx = INDEX_W'(base + $urandom_range(0, pool - 1));
            end
            send_word(op, idx, 1'b0, '0, '0);
            if (idle_on && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 10));
         end
      end

      drain_results();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: lru_index_tracker.f
hdl/lru_pkg.sv
hdl/lru_ctrl.sv
hdl/lru_datapath.sv
hdl/lru_index_tracker.sv
hdl/lru_checker.sv
tb/testbench.sv
